FILE: rtl/core/tfps_pkg.sv
// Package for the typed frame parser: types, register codes and reset values.
// Used by every module in rtl/core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfps_pkg;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_TYPE   = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_LEN_HI = 3'd3,
        PH_BODY   = 3'd4
    } phase_t;

    localparam logic [1:0] CFG_SYNC_VALUE = 2'd0;
    localparam logic [1:0] CFG_TYPE0_BODY = 2'd1;
    localparam logic [1:0] CFG_TYPE1_BODY = 2'd2;

    localparam logic [7:0]  SYNC_RESET       = 8'h55;
    localparam logic [15:0] TYPE0_BODY_RESET = 16'd894;
    localparam logic [15:0] TYPE1_BODY_RESET = 16'd126;
    localparam logic [7:0]  MAX_TYPE         = 8'h04;
    localparam logic [15:0] LEN_OVERHEAD     = 16'd4;

    typedef struct packed {
        logic [7:0]  sync_value;
        logic [15:0] type0_body_count;
        logic [15:0] type1_body_count;
    } cfg_t;

    // classified input item handed from front to back
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       is_sync;
        logic       type_ok;
    } item_t;

    typedef struct packed {
        logic [7:0]  echo_byte;
        logic        in_frame;
        logic        frame_start;
        logic [15:0] byte_position;
        logic [2:0]  frame_kind_out;
        logic        frame_end;
        logic        checksum_good;
        logic        resync;
    } result_t;

    function automatic logic [15:0] at_least_one(input logic [15:0] n);
        return (n == 16'd0) ? 16'd1 : n;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tfps_front.sv
// Front stage: takes input items and tags them as sync / legal type bytes.
// Depends on tfps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfps_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_rx_byte,
    input  wire tfps_pkg::cfg_t cfg,
    output logic               push_valid,
    input  wire logic          push_ready,
    output tfps_pkg::item_t    push_item
);
    import tfps_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.rx_byte <= s_rx_byte;
            item_reg.is_sync <= (s_rx_byte == cfg.sync_value);
            item_reg.type_ok <= (s_rx_byte <= MAX_TYPE);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tfps_queue.sv
// Two-entry item queue between the front and the parser back end.
// Depends on tfps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfps_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire tfps_pkg::item_t in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output tfps_pkg::item_t      out_item
);
    import tfps_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tfps_back.sv
// Back end: frame parse state machine, running checksum and result register.
// Depends on tfps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfps_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire tfps_pkg::cfg_t  cfg,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire tfps_pkg::item_t q_item,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output tfps_pkg::result_t    m_result
);
    import tfps_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] left_reg, left_next;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  len_low_reg, len_low_next;
    logic [15:0] pos_reg, pos_next;
    logic        m_valid_reg, m_valid_next;
    result_t     result_reg, result_next;

    logic        pop;
    logic [7:0]  b;
    logic [15:0] pos_adv;
    logic [15:0] total_len;

    assign pop       = q_valid && (!m_valid_reg || m_ready);
    assign q_ready   = pop;
    assign m_valid   = m_valid_reg;
    assign m_result  = result_reg;
    assign b         = q_item.rx_byte;
    assign pos_adv   = (pos_reg == 16'hFFFF) ? pos_reg : pos_reg + 16'd1;
    assign total_len = {b, len_low_reg};

    // next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_TYPE: begin
                if (!q_item.type_ok) begin
                    phase_next = PH_HUNT;
                end else if (b[2:0] == 3'd0 || b[2:0] == 3'd1) begin
                    phase_next = PH_BODY;
                end else begin
                    phase_next = PH_LEN_LO;
                end
            end
            PH_LEN_LO: phase_next = PH_LEN_HI;
            PH_LEN_HI: phase_next = PH_BODY;
            PH_BODY: begin
                if (left_reg <= 16'd1) begin
                    phase_next = PH_HUNT;
                end
            end
            default: begin
                phase_next = q_item.is_sync ? PH_TYPE : PH_HUNT;
            end
        endcase
    end

    // datapath state and result fields
    always_comb begin
        sum_next     = sum_reg;
        left_next    = left_reg;
        kind_next    = kind_reg;
        len_low_next = len_low_reg;
        pos_next     = pos_reg;
        result_next  = '0;
        result_next.echo_byte = b;
        case (phase_reg)
            PH_TYPE: begin
                if (q_item.type_ok) begin
                    pos_next  = 16'd1;
                    sum_next  = sum_reg + b;
                    kind_next = b[2:0];
                    if (b[2:0] == 3'd0) begin
                        left_next = at_least_one(cfg.type0_body_count);
                    end else if (b[2:0] == 3'd1) begin
                        left_next = at_least_one(cfg.type1_body_count);
                    end
                    result_next.in_frame       = 1'b1;
                    result_next.byte_position  = 16'd1;
                    result_next.frame_kind_out = b[2:0];
                end else begin
                    kind_next          = 3'd0;
                    result_next.resync = 1'b1;
                end
            end
            PH_LEN_LO: begin
                pos_next     = pos_adv;
                sum_next     = sum_reg + b;
                len_low_next = b;
                result_next.in_frame       = 1'b1;
                result_next.byte_position  = pos_adv;
                result_next.frame_kind_out = kind_reg;
            end
            PH_LEN_HI: begin
                pos_next  = pos_adv;
                sum_next  = sum_reg + b;
                // short lengths still leave the checksum byte
                left_next = (total_len < 16'd5) ? 16'd1 : total_len - LEN_OVERHEAD;
                result_next.in_frame       = 1'b1;
                result_next.byte_position  = pos_adv;
                result_next.frame_kind_out = kind_reg;
            end
            PH_BODY: begin
                pos_next = pos_adv;
                result_next.in_frame       = 1'b1;
                result_next.byte_position  = pos_adv;
                result_next.frame_kind_out = kind_reg;
                if (left_reg > 16'd1) begin
                    left_next = left_reg - 16'd1;
                    sum_next  = sum_reg + b;
                end else begin
                    left_next                 = 16'd0;
                    result_next.frame_end     = 1'b1;
                    result_next.checksum_good = (b == sum_reg);
                end
            end
            default: begin
                if (q_item.is_sync) begin
                    pos_next  = 16'd0;
                    sum_next  = b;
                    kind_next = 3'd0;
                    result_next.in_frame    = 1'b1;
                    result_next.frame_start = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            sum_reg     <= 8'd0;
            left_reg    <= 16'd0;
            kind_reg    <= 3'd0;
            len_low_reg <= 8'd0;
            pos_reg     <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                phase_reg   <= phase_next;
                sum_reg     <= sum_next;
                left_reg    <= left_next;
                kind_reg    <= kind_next;
                len_low_reg <= len_low_next;
                pos_reg     <= pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/typed_frame_parser_sum8.sv
// Top level of the typed frame parser: configuration registers, front stage,
// item queue and parser back end. Depends on tfps_pkg, tfps_front, tfps_queue, tfps_back.
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial parser for typed frames with an 8-bit sum checksum. Every
// accepted byte gives exactly one result item, in order. The block sustains
// one item per clock while m_ready stays high; a result passes the front
// register, a queue slot and the result register before it is offered, and
// stays offered while m_ready is low. The two-entry queue lets the front keep
// taking bytes while a result waits. Registers: 0 sync byte, 1 type 0 body
// count, 2 type 1 body count; writes to index 3 are ignored. Write them only
// while the block is drained. cfg_ready is always high.
module typed_frame_parser_sum8 (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_echo_byte,
    output logic             m_in_frame,
    output logic             m_frame_start,
    output logic [15:0]      m_byte_position,
    output logic [2:0]       m_frame_kind_out,
    output logic             m_frame_end,
    output logic             m_checksum_good,
    output logic             m_resync,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import tfps_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    push_valid, push_ready;
    item_t   push_item;
    logic    q_valid, q_ready;
    item_t   q_item;
    result_t result;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SYNC_VALUE: cfg_next.sync_value       = cfg_data[7:0];
                CFG_TYPE0_BODY: cfg_next.type0_body_count = cfg_data;
                CFG_TYPE1_BODY: cfg_next.type1_body_count = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_value       <= SYNC_RESET;
            cfg_reg.type0_body_count <= TYPE0_BODY_RESET;
            cfg_reg.type1_body_count <= TYPE1_BODY_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tfps_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    tfps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    tfps_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_echo_byte      = result.echo_byte;
    assign m_in_frame       = result.in_frame;
    assign m_frame_start    = result.frame_start;
    assign m_byte_position  = result.byte_position;
    assign m_frame_kind_out = result.frame_kind_out;
    assign m_frame_end      = result.frame_end;
    assign m_checksum_good  = result.checksum_good;
    assign m_resync         = result.resync;

`ifndef NO_ASSERTIONS
    // a good checksum only ever flags the closing byte of a frame
    a_good_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_checksum_good |-> m_frame_end && m_in_frame)
        else $error("checksum_good outside frame end");

    // a dropped type byte is never part of a frame
    a_resync_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_resync |-> !m_in_frame && !m_frame_start && !m_frame_end)
        else $error("resync item marked as in frame");

    // the sync byte opens at position 0 with no type yet
    a_start_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_start |-> m_byte_position == 16'd0 && m_frame_kind_out == 3'd0)
        else $error("frame start with nonzero position or kind");

    // a stalled result register must not be overwritten by the back end
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !q_ready)
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for typed_frame_parser_sum8: random and directed byte streams,
// checked item by item against a cycle-free frame parser predictor.
// Depends on tfps_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb;
    import tfps_pkg::*;

    localparam int unsigned RESET_CYCLES = 9;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned REPORT_MAX = 10;
    localparam int unsigned PHASE_ITEMS = 60;

    // frame type bytes
    localparam logic [7:0] FT_FIXED0 = 8'd0;
    localparam logic [7:0] FT_FIXED1 = 8'd1;
    localparam logic [7:0] FT_LEN2 = 8'd2;
    localparam logic [7:0] FT_LEN3 = 8'd3;
    localparam logic [7:0] FT_LEN4 = 8'd4;
    localparam logic [15:0] LEN_HDR = 16'd4;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_rx_byte = 8'd0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_echo_byte;
    logic m_in_frame;
    logic m_frame_start;
    logic [15:0] m_byte_position;
    logic [2:0] m_frame_kind_out;
    logic m_frame_end;
    logic m_checksum_good;
    logic m_resync;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;

    typed_frame_parser_sum8 u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_echo_byte(m_echo_byte),
        .m_in_frame(m_in_frame),
        .m_frame_start(m_frame_start),
        .m_byte_position(m_byte_position),
        .m_frame_kind_out(m_frame_kind_out),
        .m_frame_end(m_frame_end),
        .m_checksum_good(m_checksum_good),
        .m_resync(m_resync),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    logic [7:0] pending_bytes[$];
    result_t due_results[$];

    // register copies, written only by the sequencer at the write handshake
    logic [7:0] sync_byte = 8'h55;
    logic [15:0] t0_body = 16'd894;
    logic [15:0] t1_body = 16'd126;

    // parser state as the predictor sees it
    phase_t pr_phase;
    logic [7:0] pr_sum;
    logic [15:0] pr_left;
    logic [2:0] pr_kind;
    logic [7:0] pr_len_lo;
    logic [15:0] pr_pos;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;

    function automatic void add_byte(input logic [7:0] b);
        pending_bytes.insert(pending_bytes.size(), b);
    endfunction

    function automatic void bump_pos();
        if (pr_pos != 16'hFFFF)
            pr_pos = pr_pos + 16'd1;
    endfunction

    function automatic result_t parse_rx_byte(input logic [7:0] b);
        result_t r;
        logic [15:0] total;
        r = '0;
        r.echo_byte = b;
        case (pr_phase)
            PH_TYPE: begin
                if (b <= FT_LEN4) begin
                    pr_pos = 16'd1;
                    pr_sum = pr_sum + b;
                    pr_kind = b[2:0];
                    if (b == FT_FIXED0) begin
                        pr_left = (t0_body == 16'd0) ? 16'd1 : t0_body;
                        pr_phase = PH_BODY;
                    end else if (b == FT_FIXED1) begin
                        pr_left = (t1_body == 16'd0) ? 16'd1 : t1_body;
                        pr_phase = PH_BODY;
                    end else begin
                        pr_phase = PH_LEN_LO;
                    end
                    r.in_frame = 1'b1;
                end else begin
                    // illegal type: drop the frame, byte is not looked at as sync
                    pr_phase = PH_HUNT;
                    pr_kind = 3'd0;
                    r.resync = 1'b1;
                end
            end
            PH_LEN_LO: begin
                bump_pos();
                pr_sum = pr_sum + b;
                pr_len_lo = b;
                pr_phase = PH_LEN_HI;
                r.in_frame = 1'b1;
            end
            PH_LEN_HI: begin
                total = {b, pr_len_lo};
                bump_pos();
                pr_sum = pr_sum + b;
                pr_left = (total <= LEN_HDR) ? 16'd1 : total - LEN_HDR;
                pr_phase = PH_BODY;
                r.in_frame = 1'b1;
            end
            PH_BODY: begin
                bump_pos();
                r.in_frame = 1'b1;
                if (pr_left > 16'd1) begin
                    pr_left = pr_left - 16'd1;
                    pr_sum = pr_sum + b;
                end else begin
                    pr_left = 16'd0;
                    r.frame_end = 1'b1;
                    r.checksum_good = (b == pr_sum);
                    pr_phase = PH_HUNT;
                end
            end
            default: begin
                pr_phase = PH_HUNT;
                if (b == sync_byte) begin
                    pr_phase = PH_TYPE;
                    pr_pos = 16'd0;
                    pr_sum = b;
                    pr_kind = 3'd0;
                    r.in_frame = 1'b1;
                    r.frame_start = 1'b1;
                end
            end
        endcase
        if (r.in_frame) begin
            r.byte_position = pr_pos;
            r.frame_kind_out = pr_kind;
        end
        return r;
    endfunction

    // Builds one frame for the current register values; corrupt spoils the checksum.
    function automatic void queue_frame(input logic [7:0] kind, input logic [15:0] total,
                                        input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        int unsigned body;
        sum = sync_byte + kind;
        add_byte(sync_byte);
        add_byte(kind);
        if (kind == FT_FIXED0) begin
            body = (t0_body == 16'd0) ? 32'd1 : 32'(t0_body);
        end else if (kind == FT_FIXED1) begin
            body = (t1_body == 16'd0) ? 32'd1 : 32'(t1_body);
        end else begin
            add_byte(total[7:0]);
            add_byte(total[15:8]);
            sum = sum + total[7:0] + total[15:8];
            body = (total <= LEN_HDR) ? 32'd1 : 32'(total - LEN_HDR);
        end
        for (int unsigned i = 1; i < body; i++) begin
            b = 8'($urandom);
            add_byte(b);
            sum = sum + b;
        end
        if (corrupt)
            sum = sum + 8'($urandom_range(1, 255));
        add_byte(sum);
    endfunction

    // Mostly well-formed frames, some line noise, some frames with a bad type.
    function automatic void queue_traffic(input int unsigned n_items);
        int unsigned target;
        int unsigned pick;
        logic [7:0] b;
        logic [15:0] total;
        target = pending_bytes.size() + n_items;
        while (pending_bytes.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                if ($urandom_range(3) == 0)
                    total = 16'($urandom_range(4));
                else
                    total = 16'($urandom_range(5, 40));
                queue_frame(8'($urandom_range(4)), total, $urandom_range(3) == 0);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4)) begin
                    b = 8'($urandom);
                    if (b == sync_byte)
                        b = ~b;
                    add_byte(b);
                end
            end else begin
                add_byte(sync_byte);
                add_byte(8'($urandom_range(5, 255)));
            end
        end
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SYNC_VALUE: sync_byte = value[7:0];
            CFG_TYPE0_BODY: t0_body = value;
            CFG_TYPE1_BODY: t1_body = value;
            default: ;
        endcase
    endtask

    // returns at a rising edge once nothing is queued, offered or outstanding
    task automatic drain();
        do @(negedge aclk);
        while (pending_bytes.size() != 0 || s_valid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // driver: predicts on every accepted byte, then offers the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            pr_phase = PH_HUNT;
            pr_sum = 8'd0;
            pr_left = 16'd0;
            pr_kind = 3'd0;
            pr_len_lo = 8'd0;
            pr_pos = 16'd0;
        end else begin
            if (s_valid && s_ready)
                due_results.insert(due_results.size(), parse_rx_byte(s_rx_byte));
            if (!s_valid || s_ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_rx_byte <= pending_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result item and drives m_ready
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.echo_byte = m_echo_byte;
                got.in_frame = m_in_frame;
                got.frame_start = m_frame_start;
                got.byte_position = m_byte_position;
                got.frame_kind_out = m_frame_kind_out;
                got.frame_end = m_frame_end;
                got.checksum_good = m_checksum_good;
                got.resync = m_resync;
                if (due_results.size() == 0) begin
                    if (fail_count < REPORT_MAX)
                        $display("%0t: result item with none expected, byte %h",
                                 $realtime, got.echo_byte);
                    fail_count <= fail_count + 1;
                end else begin
                    want = due_results.pop_front();
                    if (got.echo_byte !== want.echo_byte
                            || got.in_frame !== want.in_frame
                            || got.frame_start !== want.frame_start
                            || got.byte_position !== want.byte_position
                            || got.frame_kind_out !== want.frame_kind_out
                            || got.frame_end !== want.frame_end
                            || got.checksum_good !== want.checksum_good
                            || got.resync !== want.resync) begin
                        if (fail_count < REPORT_MAX) begin
                            $display("%0t: mismatch (byte in start pos kind end good resync)",
                                     $realtime);
                            $display("  exp %h %b %b %0d %0d %b %b %b",
                                     want.echo_byte, want.in_frame, want.frame_start,
                                     want.byte_position, want.frame_kind_out,
                                     want.frame_end, want.checksum_good, want.resync);
                            $display("  got %h %b %b %0d %0d %b %b %b",
                                     got.echo_byte, got.in_frame, got.frame_start,
                                     got.byte_position, got.frame_kind_out,
                                     got.frame_end, got.checksum_good, got.resync);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                hold_left <= LONG_HOLD;
                m_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset register values; noise, bad types, short and long lengths
        @(negedge aclk);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'hAA);
        add_byte(sync_byte);
        add_byte(8'h05);
        add_byte(sync_byte);
        add_byte(8'hFF);
        // a sync value in the type slot is a bad type, not a new frame
        add_byte(sync_byte);
        add_byte(sync_byte);
        queue_frame(FT_LEN2, 16'd0, 1'b0);
        queue_frame(FT_LEN3, 16'd4, 1'b1);
        queue_frame(FT_LEN4, 16'd5, 1'b0);
        queue_frame(FT_LEN2, 16'd6, 1'b0);
        queue_frame(FT_LEN4, 16'h0105, 1'b0);
        drain();

        // zero body count acts as one; unused index must not disturb anything
        write_reg(CFG_SYNC_VALUE, {8'hA7, 8'h00});
        write_reg(CFG_TYPE0_BODY, 16'd0);
        write_reg(CFG_TYPE1_BODY, 16'd1);
        write_reg(CFG_UNUSED, 16'hFFFF);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        queue_frame(FT_FIXED0, 16'd0, 1'b0);
        queue_frame(FT_FIXED1, 16'd0, 1'b1);
        queue_traffic(PHASE_ITEMS);
        // long receiver hold while bytes keep coming
        hold_req = hold_req + 1;
        drain();

        write_reg(CFG_SYNC_VALUE, 16'h00FF);
        write_reg(CFG_TYPE0_BODY, 16'd2);
        write_reg(CFG_TYPE1_BODY, 16'd7);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        send_idle_pct = 51;
        recv_stall_pct = 0;
        queue_traffic(PHASE_ITEMS);
        drain();

        write_reg(CFG_SYNC_VALUE, 16'($urandom_range(16'hFFFF)));
        write_reg(CFG_TYPE0_BODY, 16'($urandom_range(1, 8)));
        write_reg(CFG_TYPE1_BODY, 16'($urandom_range(1, 8)));
        cfg_valid <= 1'b0;
        @(negedge aclk);
        send_idle_pct = 0;
        recv_stall_pct = 51;
        queue_traffic(PHASE_ITEMS);
        drain();

        write_reg(CFG_SYNC_VALUE, 16'h0055);
        write_reg(CFG_TYPE0_BODY, 16'd1);
        write_reg(CFG_TYPE1_BODY, 16'd3);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        send_idle_pct = 34;
        recv_stall_pct = 34;
        queue_traffic(PHASE_ITEMS);
        drain();

        if (fail_count == 0 && due_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: typed_frame_parser_sum8.f
rtl/core/tfps_pkg.sv
rtl/core/tfps_front.sv
rtl/core/tfps_queue.sv
rtl/core/tfps_back.sv
rtl/core/typed_frame_parser_sum8.sv
tb/sv/tb.sv
